// ===== rtl/fpll_pkg.sv =====
// Shared constants, types and arithmetic helpers for the four-pole ladder low-pass.
// No dependencies.
`timescale 1ns / 1ps
package fpll_pkg;
    localparam int NUM_CHANNELS = 2;
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ADDR_W = CH_W + 2;
    localparam int DEPTH = NUM_CHANNELS * 4;
    localparam int WORD_W = 40;

    localparam logic [2:0] REG_GAIN_1 = 3'd0;
    localparam logic [2:0] REG_GAIN_2 = 3'd1;
    localparam logic [2:0] REG_GAIN_3 = 3'd2;
    localparam logic [2:0] REG_GAIN_4 = 3'd3;
    localparam logic [2:0] REG_ALLPASS = 3'd4;
    localparam logic [2:0] REG_RESONANCE = 3'd5;

    localparam logic signed [39:0] SAT_HI = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] SAT_LO = -40'sh80_0000_0000;

    typedef logic signed [WORD_W-1:0] word_t;

    function automatic word_t sat40(input logic signed [41:0] v);
        if (v > 42'(SAT_HI)) return SAT_HI;
        if (v < 42'(SAT_LO)) return SAT_LO;
        return v[39:0];
    endfunction
endpackage

// ===== rtl/four_pole_ladder_lowpass_core.sv =====
// Four-pole ladder low-pass core: one sample in, one filtered sample out.
// Sequencer around a delay RAM, shared multiplier and divider.
// Depends on fpll_pkg, fpll_mul, fpll_div.
//
// Usage: stream words into s_axis (tdata = sample_in, 24 bit). Channels are
// taken in turn, starting at channel zero after reset. Each word yields one
// result on m_axis: tdata = sample_out, tuser = {slot_tag, channel}.
// Each item is processed to completion before the next word is accepted: the
// divider works out the quotient in 72 single-bit steps, the 14 products pass
// through one shared multiplier, and the four delay words are read from and
// written back to the RAM; the next word is taken once the result has moved
// into the output register.
// Reset clears the delay RAM by valid bits, the channel counter and the
// coefficients to their defaults. A stalled receiver holds the output
// register; one further item may complete and wait behind it.
// Configuration: cfg_we, cfg_addr, cfg_data, only while idle.
`timescale 1ns / 1ps
module four_pole_ladder_lowpass_core
    import fpll_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [23:0] sample_out
    output logic [2:0]  m_axis_tuser,   // [0] channel, [2:1] slot_tag
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_M0, S_M1, S_M2, S_NUM, S_DIV, S_RY, S_U, S_LOOPW,
        S_LOOPD, S_LOOPU, S_D3A, S_D3B, S_OUT
    } state_t;

    state_t state_reg;
    logic signed [31:0] g1_reg, g2_reg, g3_reg, g4_reg, a_reg;
    logic [30:0] k_reg;
    word_t mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    word_t d_reg [4];
    logic [2:0] rd_reg;
    logic [CH_W-1:0] ch_reg;
    word_t x_reg, acc_reg, y_reg, u_reg, w_reg;
    logic [1:0] j_reg;
    logic [1:0] ph_reg;
    logic ph_clr;
    logic signed [47:0] den_reg;
    word_t mx;
    logic signed [32:0] mc;
    logic msh;
    word_t mp;
    logic dstart, ddone;
    word_t dq;
    word_t rdata_reg;
    logic [ADDR_W-1:0] ra;
    logic [23:0] o_reg;
    logic [2:0] ou_reg;
    logic ov_reg;
    logic signed [63:0] kg;
    logic signed [31:0] o_t;

    fpll_mul u_mul (.aclk(aclk), .x(mx), .c(mc), .sh28(msh), .p(mp));
    fpll_div u_div (.aclk(aclk), .aresetn(aresetn), .start(dstart), .num(acc_reg),
                    .den(den_reg), .done(ddone), .quo(dq));

    assign kg = $signed({1'b0, k_reg}) * g4_reg;
    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = o_reg;
    assign m_axis_tuser = ou_reg;
    assign dstart = state_reg == S_NUM && ph_reg == 2'd2;
    assign ra = ADDR_W'({ch_reg, rd_reg[1:0]});
    assign o_t = 32'(y_reg >>> 9) + ((y_reg < 0 && y_reg[8:0] != 0) ? 32'sd1 : 32'sd0);

    always_ff @(posedge aclk) rdata_reg <= mem[ra];

    always_comb begin
        mx = d_reg[0]; mc = 33'(g3_reg); msh = 1'b0;
        case (state_reg)
            S_M0: begin mx = d_reg[0]; mc = 33'(g3_reg); end
            S_M1: begin mx = d_reg[1]; mc = 33'(g2_reg); end
            S_M2: begin mx = d_reg[2]; mc = 33'(g1_reg); end
            S_NUM: begin mx = x_reg; mc = 33'(g4_reg); end
            S_RY: begin mx = y_reg; mc = $signed({2'b0, k_reg}); msh = 1'b1; end
            S_U: begin mx = acc_reg; mc = 33'(g1_reg); end
            S_LOOPD: begin mx = w_reg; mc = 33'(a_reg); end
            S_LOOPU: begin mx = w_reg; mc = 33'(g1_reg); end
            S_D3A: begin mx = w_reg; mc = 33'(g1_reg); end
            S_D3B: begin mx = y_reg; mc = 33'(a_reg); end
            default: ;
        endcase
    end

    always_comb begin
        case (state_reg)
            S_IDLE: ph_clr = s_axis_tvalid;
            S_RD: ph_clr = rd_reg == 3'd4;
            S_DIV: ph_clr = ddone;
            S_M0, S_M1, S_M2, S_RY, S_U, S_LOOPD, S_LOOPU, S_D3A, S_D3B:
                ph_clr = ph_reg == 2'd2;
            default: ph_clr = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; ch_reg <= '0; vld_reg <= '0; ov_reg <= 1'b0; ph_reg <= '0;
            g1_reg <= 32'sd68072878; g2_reg <= 32'sd2157835; g3_reg <= 32'sd68401;
            g4_reg <= 32'sd2168; a_reg <= -32'sd2011337479; k_reg <= '0;
        end else begin
            if (ov_reg && m_axis_tready && state_reg != S_OUT) ov_reg <= 1'b0;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_GAIN_1: g1_reg <= cfg_data;
                    REG_GAIN_2: g2_reg <= cfg_data;
                    REG_GAIN_3: g3_reg <= cfg_data;
                    REG_GAIN_4: g4_reg <= cfg_data;
                    REG_ALLPASS: a_reg <= cfg_data;
                    REG_RESONANCE: k_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            ph_reg <= ph_clr ? 2'd0 : ph_reg + 2'd1;
            case (state_reg)
                S_IDLE: if (s_axis_tvalid) begin
                    x_reg <= 40'(signed'(s_axis_tdata)) <<< 9;
                    rd_reg <= '0; state_reg <= S_RD;
                    den_reg <= 48'sh1_0000_0000 + 48'(kg >>> 27);
                end
                S_RD: begin
                    rd_reg <= rd_reg + 3'd1;
                    if (rd_reg != 0)
                        d_reg[rd_reg[1:0]-2'd1] <= vld_reg[ADDR_W'({ch_reg, rd_reg[1:0]-2'd1})]
                            ? rdata_reg : '0;
                    if (rd_reg == 3'd4) state_reg <= S_M0;
                end
                S_M0: if (ph_reg == 2'd2) begin
                    acc_reg <= sat40(42'(d_reg[3]) + 42'(mp)); state_reg <= S_M1;
                end
                S_M1: if (ph_reg == 2'd2) begin
                    acc_reg <= sat40(42'(acc_reg) + 42'(mp)); state_reg <= S_M2;
                end
                S_M2: if (ph_reg == 2'd2) begin
                    acc_reg <= sat40(42'(acc_reg) + 42'(mp)); state_reg <= S_NUM;
                end
                S_NUM: begin
                    if (ph_reg == 2'd1) acc_reg <= sat40(42'(acc_reg) + 42'(mp));
                    if (ph_reg == 2'd2) state_reg <= S_DIV;
                end
                S_DIV: if (ddone) begin
                    y_reg <= dq; state_reg <= S_RY;
                end
                S_RY: if (ph_reg == 2'd2) begin
                    acc_reg <= sat40(42'(x_reg) - 42'(mp)); state_reg <= S_U;
                end
                S_U: if (ph_reg == 2'd2) begin
                    u_reg <= mp; w_reg <= sat40(42'(d_reg[0]) + 42'(mp));
                    j_reg <= '0; state_reg <= S_LOOPD;
                end
                S_LOOPD: if (ph_reg == 2'd2) begin
                    d_reg[j_reg] <= sat40(42'(u_reg) - 42'(mp));
                    state_reg <= S_LOOPU;
                end
                S_LOOPU: if (ph_reg == 2'd2) begin
                    if (j_reg == 2'd2) state_reg <= S_D3A;
                    else begin
                        u_reg <= mp; w_reg <= sat40(42'(d_reg[j_reg+2'd1]) + 42'(mp));
                        j_reg <= j_reg + 2'd1; state_reg <= S_LOOPD;
                    end
                end
                S_D3A: if (ph_reg == 2'd2) begin
                    acc_reg <= mp; state_reg <= S_D3B;
                end
                S_D3B: if (ph_reg == 2'd2) begin
                    d_reg[3] <= sat40(42'(acc_reg) - 42'(mp)); rd_reg <= '0;
                    state_reg <= S_LOOPW;
                end
                S_LOOPW: begin
                    vld_reg[ra] <= 1'b1;
                    rd_reg <= rd_reg + 3'd1;
                    if (rd_reg == 3'd3) state_reg <= S_OUT;
                end
                S_OUT: if (!ov_reg || m_axis_tready) begin
                    ov_reg <= 1'b1;
                    o_reg <= (o_t > 32'sd8388607) ? 24'h7FFFFF :
                             (o_t < -32'sd8388608) ? 24'h800000 : o_t[23:0];
                    ou_reg <= {(ch_reg == 0) ? 2'd1 : 2'd2, ch_reg[0]};
                    ch_reg <= (32'(ch_reg) == NUM_CHANNELS - 1) ? '0 : ch_reg + 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_LOOPW) mem[ra] <= d_reg[rd_reg[1:0]];
    end
endmodule

// ===== rtl/fpll_mul.sv =====
// Registered product unit: floor(x*c / 2^s) saturated to 40 bits.
// Partial products are registered, then combined. Depends on fpll_pkg.
`timescale 1ns / 1ps
module fpll_mul
    import fpll_pkg::*;
(
    input  logic               aclk,
    input  word_t              x,
    input  logic signed [32:0] c,
    input  logic               sh28,
    output word_t              p
);
    logic signed [57:0] hi_reg;
    logic signed [49:0] lo_reg;
    logic               sh_reg;
    logic signed [23:0] hi_w;
    logic signed [16:0] lo_w;
    logic signed [73:0] m;
    logic signed [73:0] sh;

    assign hi_w = x[39:16];
    assign lo_w = {1'b0, x[15:0]};

    always_ff @(posedge aclk) begin
        hi_reg <= 58'(hi_w * c);
        lo_reg <= 50'(lo_w * c);
        sh_reg <= sh28;
    end

    always_comb begin
        m = (74'(hi_reg) <<< 16) + 74'(lo_reg);
        sh = sh_reg ? (m >>> 28) : (m >>> 31);
        if (sh > 74'(SAT_HI)) p = SAT_HI;
        else if (sh < 74'(SAT_LO)) p = SAT_LO;
        else p = sh[39:0];
    end
endmodule

// ===== rtl/fpll_div.sv =====
// Restoring divider for the feedback solve: Q8.32 quotient, truncated, saturated.
// One quotient bit per cycle. Depends on fpll_pkg.
`timescale 1ns / 1ps
module fpll_div
    import fpll_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  word_t              num,
    input  logic signed [47:0] den,
    output logic               done,
    output word_t              quo
);
    logic [71:0] n_reg;
    logic [47:0] d_reg;
    logic [48:0] r_reg;
    logic [41:0] q_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, neg_reg, zero_reg, nz_reg, numz_reg;
    logic [48:0] r_sh;
    logic [41:0] q_sh;

    assign r_sh = {r_reg[47:0], n_reg[71]};
    assign q_sh = {q_reg[40:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
        end else begin
            done <= !start && busy_reg && cnt_reg == 7'd1;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 7'd72;
                n_reg <= {(num < 0) ? 40'(-num) : num, 32'd0};
                d_reg <= (den < 0) ? 48'(-den) : den;
                neg_reg <= (num < 0) != (den < 0);
                zero_reg <= den == 0;
                nz_reg <= num < 0;
                numz_reg <= num == 0;
                r_reg <= '0;
                q_reg <= '0;
            end else if (busy_reg) begin
                n_reg <= n_reg << 1;
                r_reg <= (r_sh >= {1'b0, d_reg}) ? r_sh - {1'b0, d_reg} : r_sh;
                if (q_reg[40] || q_reg[41]) q_reg <= 42'h100_0000_0000;
                else q_reg <= (r_sh >= {1'b0, d_reg}) ? (q_sh | 42'd1) : q_sh;
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) busy_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        if (zero_reg) quo = numz_reg ? '0 : (nz_reg ? SAT_LO : SAT_HI);
        else if (q_reg[41] || q_reg[40]) quo = neg_reg ? SAT_LO : SAT_HI;
        else if (q_reg[39]) quo = neg_reg ? (q_reg[38:0] == 0 ? SAT_LO : SAT_LO) : SAT_HI;
        else quo = neg_reg ? -word_t'(q_reg[39:0]) : word_t'(q_reg[39:0]);
    end
endmodule
